[rtl/core/frs_pkg.sv]
// Shared types, constants and helpers for the fixed-wing attitude rate setpoint block.
// Used by the CORDIC cell, trig unit, divide cell and top level; no dependencies.
package frs_pkg;

  localparam int AngleFracBits = 13;
  localparam int GainFracBits  = 12;
  localparam int TrigStagesDef = 16;
  localparam int AtanLen       = 24;
  localparam int QuotBits      = 17;

  localparam int CompShift = 42 - AngleFracBits;
  localparam int CompBits  = 48 - CompShift;
  localparam int RateShift = 38 - AngleFracBits;
  localparam int GravShift = AngleFracBits - 8;

  localparam logic signed [34:0] Q30Pi     = 35'sd3373259426;
  localparam logic signed [34:0] Q30HalfPi = 35'sd1686629713;
  localparam logic signed [34:0] Q30TwoPi  = 35'sd6746518852;
  localparam logic signed [31:0] CordicK   = 32'sd652032874;
  localparam logic signed [20:0] GravityQ16 = 21'sd642908;
  localparam logic signed [63:0] Q30Half   = 64'sd536870912;

  localparam logic [31:0] AtanQ30 [AtanLen] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  typedef enum logic [2:0] {
    RegRollGain      = 3'd0,
    RegPitchGain     = 3'd1,
    RegRollRateLimit = 3'd2,
    RegPitchRateLimit = 3'd3,
    RegRollCompGain  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic signed [15:0] roll_setpoint;
    logic signed [15:0] pitch_setpoint;
    logic signed [15:0] roll_measured;
    logic signed [15:0] pitch_measured;
    logic signed [15:0] roll_rate_measured;
    logic signed [15:0] speed_forward;
    logic signed [15:0] speed_down;
  } in_t;

  typedef struct packed {
    logic signed [15:0] roll_rate_cmd;
    logic signed [15:0] pitch_rate_cmd;
    logic signed [15:0] yaw_rate_cmd;
    logic               yaw_flag;
  } out_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [34:0] z;
    logic               neg;
  } cordic_t;

  typedef struct packed {
    logic signed [15:0] pitch_sp;
    logic signed [15:0] pitch_m;
    logic signed [15:0] rate_m;
    logic signed [15:0] vx;
    logic signed [15:0] roll_cmd;
    logic signed [15:0] pitch_cmd;
    logic signed [31:0] sr;
    logic [47:0]        comp_prod;
    logic signed [20:0] perr;
    logic signed [63:0] p1;
    logic signed [63:0] p2;
    logic signed [33:0] m1;
    logic signed [33:0] m2;
    logic signed [47:0] vzs;
    logic signed [31:0] rr;
    logic signed [54:0] g1;
    logic signed [51:0] den;
    logic signed [31:0] vp;
    logic signed [63:0] t3;
    logic signed [63:0] num;
  } post_t;

  typedef struct packed {
    logic [63:0]          r;
    logic [51:0]          da;
    logic [QuotBits-1:0]  q;
    logic                 neg;
    logic                 dz;
    logic                 ovf;
    logic signed [15:0]   roll_cmd;
    logic signed [15:0]   pitch_cmd;
  } div_t;

  // Proportional step: round the Q4.12 product back to the angle format, then clamp.
  function automatic logic signed [15:0] p_clamp(input logic signed [39:0] prod,
                                                 input logic [14:0] lim);
    logic signed [39:0] v;
    logic signed [39:0] l;
    v = (prod + 40'(2 ** (GainFracBits - 1))) >>> GainFracBits;
    l = $signed({25'd0, lim});
    if (v > l) return l[15:0];
    if (v < -l) return 16'(-l);
    return v[15:0];
  endfunction

endpackage

[rtl/core/fixed_wing_attitude_rate_setpoint.sv]
// Throughput: one word per cycle; the whole pipeline advances whenever the output
// register is empty or being taken, so three CORDIC rows of TRIG_STAGES cells and a
// 17-cell divide row all move together. Reset clears valid bits and loads the
// configuration registers with their defaults; datapath registers are not reset.
// Depends on frs_pkg, frs_trig, frs_cordic_cell and frs_div_cell.
module fixed_wing_attitude_rate_setpoint #(
  parameter int TRIG_STAGES = frs_pkg::TrigStagesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  frs_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output frs_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i
);

  localparam int Depth = TRIG_STAGES + 28;
  localparam int QB    = frs_pkg::QuotBits;

  logic        pipe_en;
  logic [Depth-1:0] vld_q;

  logic [15:0] roll_gain_q, pitch_gain_q, comp_gain_q;
  logic [14:0] roll_lim_q, pitch_lim_q;

  frs_pkg::in_t  in_q;
  frs_pkg::in_t  side_q [TRIG_STAGES+1];
  frs_pkg::out_t out_d, out_q;

  logic signed [31:0] sin_sp, sin_rm, cos_rm, sin_pm, cos_pm;

  logic signed [16:0] roll_err;
  logic signed [39:0] roll_prod, pitch_prod;
  logic [31:0]        abs_ssp;
  logic [47:0]        comp_sum;
  logic [frs_pkg::CompBits-1:0] comp;

  frs_pkg::post_t pa_d, pa_q, pb_d, pb_q, pc_d, pc_q, pd_d, pd_q;
  frs_pkg::post_t pe_d, pe_q, pf_d, pf_q, pg_d, pg_q;
  frs_pkg::div_t  hd_d;
  frs_pkg::div_t  dv [QB+1];

  assign pipe_en     = !out_valid_o || out_ready_i;
  assign in_ready_o  = pipe_en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_gain_q  <= 16'd4096;
      pitch_gain_q <= 16'd4096;
      roll_lim_q   <= 15'd8192;
      pitch_lim_q  <= 15'd8192;
      comp_gain_q  <= 16'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        frs_pkg::RegRollGain:       roll_gain_q  <= cfg_data_i;
        frs_pkg::RegPitchGain:      pitch_gain_q <= cfg_data_i;
        frs_pkg::RegRollRateLimit:  roll_lim_q   <= cfg_data_i[14:0];
        frs_pkg::RegPitchRateLimit: pitch_lim_q  <= cfg_data_i[14:0];
        frs_pkg::RegRollCompGain:   comp_gain_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      in_q      <= in_data_i;
      side_q[0] <= in_q;
      for (int k = 1; k <= TRIG_STAGES; k++) side_q[k] <= side_q[k-1];
    end
  end

  frs_trig #(.TRIG_STAGES(TRIG_STAGES)) u_trig_sp (
    .clk_i(clk_i), .en_i(pipe_en), .angle_i(in_q.roll_setpoint),
    .sin_o(sin_sp), .cos_o()
  );
  frs_trig #(.TRIG_STAGES(TRIG_STAGES)) u_trig_rm (
    .clk_i(clk_i), .en_i(pipe_en), .angle_i(in_q.roll_measured),
    .sin_o(sin_rm), .cos_o(cos_rm)
  );
  frs_trig #(.TRIG_STAGES(TRIG_STAGES)) u_trig_pm (
    .clk_i(clk_i), .en_i(pipe_en), .angle_i(in_q.pitch_measured),
    .sin_o(sin_pm), .cos_o(cos_pm)
  );

  // Roll command, trig products and compensation product.
  always_comb begin
    roll_err  = 17'(side_q[TRIG_STAGES].roll_setpoint) - 17'(side_q[TRIG_STAGES].roll_measured);
    roll_prod = 40'($signed({1'b0, roll_gain_q})) * 40'(roll_err);
    abs_ssp   = sin_sp[31] ? 32'(-sin_sp) : 32'(sin_sp);
    pa_d           = '0;
    pa_d.pitch_sp  = side_q[TRIG_STAGES].pitch_setpoint;
    pa_d.pitch_m   = side_q[TRIG_STAGES].pitch_measured;
    pa_d.rate_m    = side_q[TRIG_STAGES].roll_rate_measured;
    pa_d.vx        = side_q[TRIG_STAGES].speed_forward;
    pa_d.roll_cmd  = frs_pkg::p_clamp(roll_prod, roll_lim_q);
    pa_d.sr        = sin_rm;
    pa_d.comp_prod = 48'(abs_ssp) * 48'(comp_gain_q);
    pa_d.p1        = 64'(sin_rm) * 64'(cos_pm);
    pa_d.p2        = 64'(cos_rm) * 64'(cos_pm);
    pa_d.vzs       = 48'(side_q[TRIG_STAGES].speed_down) * 48'(sin_pm);
  end

  // Rounding of the trig products and of the compensation; pitch error.
  always_comb begin
    comp_sum = pa_q.comp_prod + 48'(2 ** (frs_pkg::CompShift - 1));
    comp     = comp_sum[47:frs_pkg::CompShift];
    pb_d      = pa_q;
    pb_d.perr = 21'(pa_q.pitch_sp) + $signed(21'(comp)) - 21'(pa_q.pitch_m);
    pb_d.m1   = 34'((pa_q.p1 + frs_pkg::Q30Half) >>> 30);
    pb_d.m2   = 34'((pa_q.p2 + frs_pkg::Q30Half) >>> 30);
    pb_d.rr   = 32'(pa_q.rate_m) * 32'(pa_q.roll_cmd);
  end

  always_comb begin
    pitch_prod     = 40'($signed({1'b0, pitch_gain_q})) * 40'(pb_q.perr);
    pc_d           = pb_q;
    pc_d.pitch_cmd = frs_pkg::p_clamp(pitch_prod, pitch_lim_q);
    pc_d.g1        = 55'(frs_pkg::GravityQ16) * 55'(pb_q.m1);
    pc_d.den       = 52'(pb_q.vx) * 52'(pb_q.m2) + 52'(pb_q.vzs);
  end

  always_comb begin
    pd_d    = pc_q;
    pd_d.vp = 32'(pc_q.vx) * 32'(pc_q.pitch_cmd);
  end

  always_comb begin
    pe_d    = pd_q;
    pe_d.t3 = 64'(pd_q.vp) * 64'(pd_q.sr);
  end

  always_comb begin
    pf_d     = pe_q;
    pf_d.num = (64'(pe_q.rr) <<< frs_pkg::RateShift)
             + (64'(pe_q.g1) <<< frs_pkg::GravShift) + pe_q.t3;
  end

  always_comb begin
    pg_d = pf_q;
  end

  // Magnitudes and signs for the divider; a quotient of 2^17 or more saturates anyway.
  always_comb begin
    hd_d.r         = pg_q.num[63] ? 64'(-pg_q.num) : 64'(pg_q.num);
    hd_d.da        = pg_q.den[51] ? 52'(-pg_q.den) : 52'(pg_q.den);
    hd_d.q         = '0;
    hd_d.neg       = pg_q.num[63] ^ pg_q.den[51];
    hd_d.dz        = (pg_q.den == '0);
    hd_d.ovf       = {5'b0, hd_d.r} >= {hd_d.da, {QB{1'b0}}};
    hd_d.roll_cmd  = pg_q.roll_cmd;
    hd_d.pitch_cmd = pg_q.pitch_cmd;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      pa_q  <= pa_d;
      pb_q  <= pb_d;
      pc_q  <= pc_d;
      pd_q  <= pd_d;
      pe_q  <= pe_d;
      pf_q  <= pf_d;
      pg_q  <= pg_d;
      dv[0] <= hd_d;
      out_q <= out_d;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    frs_div_cell #(.SHIFT(QB - 1 - j)) u_div (
      .clk_i  (clk_i),
      .en_i   (pipe_en),
      .cell_i (dv[j]),
      .cell_o (dv[j+1])
    );
  end

  always_comb begin
    out_d.roll_rate_cmd  = dv[QB].roll_cmd;
    out_d.pitch_rate_cmd = dv[QB].pitch_cmd;
    out_d.yaw_flag       = 1'b0;
    if (dv[QB].dz) begin
      out_d.yaw_rate_cmd = '0;
      out_d.yaw_flag     = 1'b1;
    end else if (dv[QB].ovf) begin
      out_d.yaw_rate_cmd = dv[QB].neg ? 16'sh8000 : 16'sh7FFF;
      out_d.yaw_flag     = 1'b1;
    end else if (!dv[QB].neg) begin
      if (dv[QB].q > QB'(32767)) begin
        out_d.yaw_rate_cmd = 16'sh7FFF;
        out_d.yaw_flag     = 1'b1;
      end else begin
        out_d.yaw_rate_cmd = dv[QB].q[15:0];
      end
    end else begin
      if (dv[QB].q > QB'(32768)) begin
        out_d.yaw_rate_cmd = 16'sh8000;
        out_d.yaw_flag     = 1'b1;
      end else begin
        out_d.yaw_rate_cmd = 16'(-dv[QB].q);
      end
    end
  end

  assign out_valid_o = vld_q[Depth-1];
  assign out_data_o  = out_q;

endmodule

[rtl/core/frs_cordic_cell.sv]
// One rotation-mode CORDIC micro-rotation with its own stage register.
// Depends on frs_pkg for the cell type and the arctangent table.
module frs_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  frs_pkg::cordic_t cell_i,
  output frs_pkg::cordic_t cell_o
);

  localparam logic signed [34:0] Atan = $signed({3'b000, frs_pkg::AtanQ30[IDX]});

  frs_pkg::cordic_t cell_d, cell_q;

  always_comb begin
    cell_d = cell_i;
    if (!cell_i.z[34]) begin
      cell_d.x = cell_i.x - (cell_i.y >>> IDX);
      cell_d.y = cell_i.y + (cell_i.x >>> IDX);
      cell_d.z = cell_i.z - Atan;
    end else begin
      cell_d.x = cell_i.x + (cell_i.y >>> IDX);
      cell_d.y = cell_i.y - (cell_i.x >>> IDX);
      cell_d.z = cell_i.z + Atan;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) cell_q <= cell_d;
  end

  assign cell_o = cell_q;

endmodule

[rtl/core/frs_trig.sv]
// Sine and cosine in Q1.30 of one angle: range fold stage, then a row of CORDIC cells.
// Depends on frs_pkg and frs_cordic_cell.
module frs_trig #(
  parameter int TRIG_STAGES = frs_pkg::TrigStagesDef
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [15:0] angle_i,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  logic signed [34:0] z_scaled, z_wrap;
  frs_pkg::cordic_t   start_d, start_q;
  frs_pkg::cordic_t   chain [TRIG_STAGES+1];

  always_comb begin
    z_scaled = 35'(angle_i) <<< (30 - frs_pkg::AngleFracBits);
    if (z_scaled > frs_pkg::Q30Pi) begin
      z_wrap = z_scaled - frs_pkg::Q30TwoPi;
    end else if (z_scaled < -frs_pkg::Q30Pi) begin
      z_wrap = z_scaled + frs_pkg::Q30TwoPi;
    end else begin
      z_wrap = z_scaled;
    end
    start_d.x   = frs_pkg::CordicK;
    start_d.y   = '0;
    start_d.z   = z_wrap;
    start_d.neg = 1'b0;
    // Angles beyond a quarter turn are mirrored; the cosine sign flips.
    if (z_wrap > frs_pkg::Q30HalfPi) begin
      start_d.z   = frs_pkg::Q30Pi - z_wrap;
      start_d.neg = 1'b1;
    end else if (z_wrap < -frs_pkg::Q30HalfPi) begin
      start_d.z   = -frs_pkg::Q30Pi - z_wrap;
      start_d.neg = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) start_q <= start_d;
  end

  assign chain[0] = start_q;

  for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_cell
    frs_cordic_cell #(.IDX(i)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .cell_i (chain[i]),
      .cell_o (chain[i+1])
    );
  end

  assign sin_o = chain[TRIG_STAGES].y;
  assign cos_o = chain[TRIG_STAGES].neg ? -chain[TRIG_STAGES].x : chain[TRIG_STAGES].x;

endmodule

[rtl/core/frs_div_cell.sv]
// One restoring-division step producing a single quotient bit, with its stage register.
// Depends on frs_pkg for the divide word type.
module frs_div_cell #(
  parameter int SHIFT = 0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  frs_pkg::div_t cell_i,
  output frs_pkg::div_t cell_o
);

  logic [68:0]   sub;
  frs_pkg::div_t cell_d, cell_q;

  always_comb begin
    sub    = 69'(cell_i.da) << SHIFT;
    cell_d = cell_i;
    if ({5'b0, cell_i.r} >= sub) begin
      cell_d.r        = cell_i.r - sub[63:0];
      cell_d.q[SHIFT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) cell_q <= cell_d;
  end

  assign cell_o = cell_q;

endmodule
